@@ rtl/core/flvat_pkg.sv @@
package flvat_pkg;

    // Work kinds handed from the parser to the output sequencer
    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_START,
        KIND_MARKER
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [39:0] hdr;     // frame type, codec id, packet type, composition time
        logic        eot;
        logic        trunc;
    } entry_t;

    localparam logic [7:0] START_TAIL  = 8'h01;
    localparam logic [3:0] CODEC_AVC   = 4'd7;
    localparam logic [7:0] PKT_SEQ_HDR = 8'd0;
    localparam logic [7:0] PKT_NALU    = 8'd1;

    // Byte positions inside the tag body; the counter saturates at POS_MAX
    localparam int         POS_W       = 4;
    localparam logic [POS_W-1:0] POS_FRAME   = 4'd0;
    localparam logic [POS_W-1:0] POS_PKT     = 4'd1;
    localparam logic [POS_W-1:0] POS_CT_HI   = 4'd2;
    localparam logic [POS_W-1:0] POS_CT_MID  = 4'd3;
    localparam logic [POS_W-1:0] POS_CT_LO   = 4'd4;
    localparam logic [POS_W-1:0] POS_NLS     = 4'd9;
    localparam logic [POS_W-1:0] POS_CFG_END = 4'd10;
    localparam logic [POS_W-1:0] POS_MAX     = 4'd15;

    localparam logic [2:0] NLS_RESET   = 3'd4;
    localparam logic [2:0] PS_LEN_SIZE = 3'd2;

endpackage

@@ rtl/core/flvat_if.sv @@
interface flvat_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] tag_byte;
    logic       tag_is_video;
    logic       last_byte;

    modport source (output valid, tag_byte, tag_is_video, last_byte, input ready);
    modport sink   (input valid, tag_byte, tag_is_video, last_byte, output ready);
endinterface

interface flvat_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        end_of_tag;
    logic [3:0]  frame_type;
    logic [3:0]  codec_id;
    logic [7:0]  packet_kind;
    logic [23:0] composition_time;
    logic        truncated;

    modport source (output valid, out_byte, byte_valid, end_of_tag, frame_type, codec_id,
                    packet_kind, composition_time, truncated, input ready);
    modport sink   (input valid, out_byte, byte_valid, end_of_tag, frame_type, codec_id,
                    packet_kind, composition_time, truncated, output ready);
endinterface

@@ rtl/core/flvat_front.sv @@
module flvat_front import flvat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    flvat_in_if.sink   tag,
    output logic       push,
    output entry_t     push_entry,
    input  logic       full
);

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_SKIP,
        PH_CFG_PRE,
        PH_SPS_LEN,
        PH_SPS_DATA,
        PH_PPS_COUNT,
        PH_PPS_LEN,
        PH_PPS_DATA,
        PH_NAL_LEN,
        PH_NAL_DATA
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [2:0]         nls_reg, nls_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [31:0]        acc_reg, acc_next;
    logic [2:0]         seen_reg, seen_next;
    logic [31:0]        rem_reg, rem_next;
    logic [39:0]        hdr_reg, hdr_next;

    logic               accept;
    logic               push_req;
    logic [31:0]        acc_sh;
    logic [2:0]         seen_inc;

    assign tag.ready = !full;
    assign accept    = tag.valid && !full;
    assign push      = accept && push_req;
    assign acc_sh    = {acc_reg[23:0], tag.tag_byte};
    assign seen_inc  = seen_reg + 3'd1;

    always_comb
    begin
        phase_next = phase_reg;
        nls_next   = nls_reg;
        pos_next   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        acc_next   = acc_reg;
        seen_next  = seen_reg;
        rem_next   = rem_reg;
        hdr_next   = hdr_reg;
        push_req   = 1'b0;
        push_entry = '{kind: KIND_DATA, data: tag.tag_byte, hdr: 40'd0, eot: 1'b0,
                       trunc: 1'b0};

        case (phase_reg)
            PH_HEADER:
            begin
                case (pos_reg)
                    POS_FRAME:
                    begin
                        hdr_next = {tag.tag_byte, 32'd0};
                        if (!(tag.tag_is_video && tag.tag_byte[3:0] == CODEC_AVC))
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    POS_PKT:    hdr_next[31:24] = tag.tag_byte;
                    POS_CT_HI:  hdr_next[23:16] = tag.tag_byte;
                    POS_CT_MID: hdr_next[15:8]  = tag.tag_byte;
                    default:
                    begin
                        hdr_next[7:0] = tag.tag_byte;
                        acc_next      = '0;
                        seen_next     = '0;
                        if (hdr_reg[31:24] == PKT_SEQ_HDR)
                        begin
                            phase_next = PH_CFG_PRE;
                        end
                        else if (hdr_reg[31:24] == PKT_NALU)
                        begin
                            phase_next = PH_NAL_LEN;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                endcase
            end
            PH_CFG_PRE:
            begin
                if (pos_reg == POS_NLS)
                begin
                    nls_next = {1'b0, tag.tag_byte[1:0]} + 3'd1;
                end
                if (pos_reg >= POS_CFG_END)
                begin
                    phase_next = PH_SPS_LEN;
                    acc_next   = '0;
                    seen_next  = '0;
                end
            end
            PH_SPS_LEN, PH_PPS_LEN:
            begin
                if (seen_inc >= PS_LEN_SIZE)
                begin
                    push_req        = 1'b1;
                    push_entry.kind = KIND_START;
                    rem_next        = {16'd0, acc_sh[15:0]};
                    acc_next        = '0;
                    seen_next       = '0;
                    if (phase_reg == PH_SPS_LEN)
                    begin
                        phase_next = (acc_sh[15:0] != 16'd0) ? PH_SPS_DATA : PH_PPS_COUNT;
                    end
                    else
                    begin
                        phase_next = (acc_sh[15:0] != 16'd0) ? PH_PPS_DATA : PH_SKIP;
                    end
                end
                else
                begin
                    acc_next  = acc_sh;
                    seen_next = seen_inc;
                end
            end
            PH_SPS_DATA, PH_PPS_DATA, PH_NAL_DATA:
            begin
                push_req = 1'b1;
                rem_next = rem_reg - 32'd1;
                if (rem_reg == 32'd1)
                begin
                    case (phase_reg)
                        PH_SPS_DATA: phase_next = PH_PPS_COUNT;
                        PH_PPS_DATA: phase_next = PH_SKIP;
                        default:     phase_next = PH_NAL_LEN;
                    endcase
                end
            end
            PH_PPS_COUNT:
            begin
                phase_next = PH_PPS_LEN;
                acc_next   = '0;
                seen_next  = '0;
            end
            PH_NAL_LEN:
            begin
                if (seen_inc >= nls_reg)
                begin
                    push_req        = 1'b1;
                    push_entry.kind = KIND_START;
                    rem_next        = acc_sh;
                    acc_next        = '0;
                    seen_next       = '0;
                    if (acc_sh != 32'd0)
                    begin
                        phase_next = PH_NAL_DATA;
                    end
                end
                else
                begin
                    acc_next  = acc_sh;
                    seen_next = seen_inc;
                end
            end
            default:
            begin
            end
        endcase

        push_entry.hdr = hdr_next;

        // Close the tag: flag the last word, add a marker if nothing else goes out
        if (tag.last_byte)
        begin
            if (!push_req)
            begin
                push_req        = 1'b1;
                push_entry.kind = KIND_MARKER;
                push_entry.data = 8'd0;
            end
            push_entry.eot = 1'b1;
            if (phase_next == PH_NAL_LEN)
            begin
                push_entry.trunc = (seen_next != 3'd0);
            end
            else
            begin
                push_entry.trunc = (phase_next != PH_SKIP);
            end
            phase_next = PH_HEADER;
            pos_next   = '0;
            acc_next   = '0;
            seen_next  = '0;
            rem_next   = '0;
            hdr_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            nls_reg   <= NLS_RESET;
            pos_reg   <= '0;
            acc_reg   <= '0;
            seen_reg  <= '0;
            rem_reg   <= '0;
            hdr_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            nls_reg   <= nls_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
            rem_reg   <= rem_next;
            hdr_reg   <= hdr_next;
        end
    end

endmodule

@@ rtl/core/flvat_fifo.sv @@
module flvat_fifo import flvat_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t head,
    output logic   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t           slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/core/flvat_back.sv @@
module flvat_back import flvat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  entry_t      head,
    input  logic        empty,
    output logic        pop,
    flvat_out_if.source annexb
);

    logic        valid_reg;
    logic [1:0]  sc_reg;
    logic [7:0]  byte_reg;
    logic        bvalid_reg;
    logic        eot_reg;
    logic        trunc_reg;
    logic [39:0] hdr_reg;

    logic        load;
    logic        final_piece;
    logic [7:0]  byte_next;

    assign load        = !valid_reg || annexb.ready;
    assign final_piece = (head.kind != KIND_START) || (sc_reg == 2'd3);
    assign pop         = load && !empty && final_piece;

    always_comb
    begin
        case (head.kind)
            KIND_DATA:  byte_next = head.data;
            KIND_START: byte_next = (sc_reg == 2'd3) ? START_TAIL : 8'd0;
            default:    byte_next = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sc_reg    <= '0;
        end
        else if (load)
        begin
            valid_reg <= !empty;
            if (!empty)
            begin
                sc_reg <= final_piece ? 2'd0 : sc_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            byte_reg   <= byte_next;
            bvalid_reg <= (head.kind != KIND_MARKER);
            eot_reg    <= head.eot && final_piece;
            trunc_reg  <= head.trunc && final_piece;
            hdr_reg    <= head.hdr;
        end
    end

    assign annexb.valid            = valid_reg;
    assign annexb.out_byte         = byte_reg;
    assign annexb.byte_valid       = bvalid_reg;
    assign annexb.end_of_tag       = eot_reg;
    assign annexb.truncated        = trunc_reg;
    assign annexb.frame_type       = hdr_reg[39:36];
    assign annexb.codec_id         = hdr_reg[35:32];
    assign annexb.packet_kind      = hdr_reg[31:24];
    assign annexb.composition_time = hdr_reg[23:0];

endmodule

@@ rtl/core/flv_avc_tag_to_annexb_unit.sv @@
// FLV video tag body to H.264 Annex B converter.
//
// tag    : one tag body byte per word, with tag_is_video (looked at on the
//          first byte only) and last_byte marking the final byte of a tag.
// annexb : Annex B bytes (start codes 00 00 00 01 and NAL payload) with the
//          header fields of the tag they belong to. The last word of every
//          tag has end_of_tag set; a tag that ends on a byte producing no
//          output gets a marker word with byte_valid low.
//
// An accepted byte passes through the entry queue to the output register.
// Throughput is one byte per cycle through payload while the receiver is
// ready; each start code takes four output words, and the parser keeps
// accepting while the queue (QUEUE_DEPTH entries) has room, absorbing bursts.
// Reset clears the parser, queue and output register and sets the NAL length
// size to 4. When the receiver stalls, the output word holds, the queue fills
// and tag.ready drops once the queue is full.
module flv_avc_tag_to_annexb_unit import flvat_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    flvat_in_if.sink    tag,
    flvat_out_if.source annexb
);

    logic   push;
    entry_t push_entry;
    logic   full;
    logic   pop;
    entry_t head;
    logic   empty;

    // Parse tag bytes, track the NAL framing, emit one entry per output event
    flvat_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tag        (tag),
        .push       (push),
        .push_entry (push_entry),
        .full       (full)
    );

    // Decouple the parser from the output sequencer
    flvat_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    // Expand entries into output words: start codes become four words
    flvat_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .annexb (annexb)
    );

endmodule

@@ rtl/core/flvat_checker.sv @@
module flvat_checker import flvat_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic [7:0]  out_byte,
    input logic        byte_valid,
    input logic        end_of_tag,
    input logic [3:0]  codec_id,
    input logic        truncated
);

    // Hold the word while the receiver stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(out_byte) && $stable(end_of_tag))
    else $error("output word changed while stalled");

    // Marker words only close a tag and carry a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !byte_valid |-> end_of_tag && out_byte == 8'd0)
    else $error("marker word outside tag end");

    // Truncation is reported only on the closing word
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && truncated |-> end_of_tag)
    else $error("truncated without end_of_tag");

    // Only AVC tags can be truncated
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && truncated |-> codec_id == CODEC_AVC)
    else $error("truncated on a non-AVC tag");

endmodule

bind flv_avc_tag_to_annexb_unit flvat_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid      (annexb.valid),
    .ready      (annexb.ready),
    .out_byte   (annexb.out_byte),
    .byte_valid (annexb.byte_valid),
    .end_of_tag (annexb.end_of_tag),
    .codec_id   (annexb.codec_id),
    .truncated  (annexb.truncated)
);

@@ dv/tb_top.sv @@
module tb_top;
    import flvat_pkg::*;

    // Run shape: random AVC tag bytes, idle limit of the watchdog, tail after the
    // last expected word, and the length of each long sink hold-off.
    localparam int RANDOM_BYTES = 320;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 30;
    localparam int SINK_HOLD    = 300;

    // One word of the Annex B side, laid out field by field as the port shows it.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        end_of_tag;
        logic [3:0]  frame_type;
        logic [3:0]  codec_id;
        logic [7:0]  packet_kind;
        logic [23:0] composition_time;
        logic        truncated;
    } annexb_word_t;

    // Where the converter stands inside the current tag body.
    typedef enum logic [3:0] {
        P_HDR,
        P_SKIP,
        P_CFG,
        P_SPS_LEN,
        P_SPS_BODY,
        P_PPS_CNT,
        P_PPS_LEN,
        P_PPS_BODY,
        P_NAL_LEN,
        P_NAL_BODY
    } conv_phase_t;

    // One row of the directed table. Rows with typed set carry the single word
    // they must produce; all other rows are checked against the converter model.
    typedef struct packed {
        logic [7:0]   tag_byte;
        logic         video;
        logic         last;
        logic         typed;
        annexb_word_t gold;
    } stim_row_t;

    localparam annexb_word_t NO_WORD = '0;

    logic clk = 1'b0;
    logic rst_n;

    flvat_in_if  tag_if ();
    flvat_out_if annexb_if ();

    flv_avc_tag_to_annexb_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tag    (tag_if),
        .annexb (annexb_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Converter model: its own copy of the parser state. The NAL length size
    // survives tag ends, everything else is cleared on each last byte.
    // ------------------------------------------------------------------
    logic [2:0]   cur_nls;
    logic [31:0]  cur_pos;
    conv_phase_t  cur_phase;
    logic [31:0]  len_acc;
    logic [2:0]   len_seen;
    logic [31:0]  payload_left;
    logic [39:0]  tag_hdr;

    annexb_word_t burst[$];           // words caused by the byte just converted
    annexb_word_t expected_words[$];  // words still owed by the block, oldest first

    int  mismatches = 0;
    logic src_burst = 1'b0;           // sender runs without gaps for this tag
    logic sink_holding = 1'b0;        // sink is in a long hold-off

    function automatic void clear_tag_state();
        cur_pos      = '0;
        cur_phase    = P_HDR;
        len_acc      = '0;
        len_seen     = '0;
        payload_left = '0;
        tag_hdr      = '0;
    endfunction

    // Append one word stamped with the header fields seen so far.
    function automatic void emit(input logic [7:0] b, input logic v);
        annexb_word_t w;
        w.out_byte         = b;
        w.byte_valid       = v;
        w.end_of_tag       = 1'b0;
        w.frame_type       = tag_hdr[39:36];
        w.codec_id         = tag_hdr[35:32];
        w.packet_kind      = tag_hdr[31:24];
        w.composition_time = tag_hdr[23:0];
        w.truncated        = 1'b0;
        burst.push_back(w);
    endfunction

    function automatic void emit_start_code();
        emit(8'h00, 1'b1);
        emit(8'h00, 1'b1);
        emit(8'h00, 1'b1);
        emit(START_TAIL, 1'b1);
    endfunction

    // Convert one tag byte; the words it causes land in burst.
    function automatic void convert_byte(input logic [7:0] b, input logic video,
                                         input logic last);
        logic trunc;
        burst.delete();
        case (cur_phase)
            P_HDR:
            begin
                if (cur_pos == POS_FRAME)
                begin
                    tag_hdr   = {b, 32'h0};
                    cur_phase = (video && b[3:0] == CODEC_AVC) ? P_HDR : P_SKIP;
                end
                else if (cur_pos == POS_PKT)
                begin
                    tag_hdr[31:24] = b;
                end
                else if (cur_pos == POS_CT_HI)
                begin
                    tag_hdr[23:16] = b;
                end
                else if (cur_pos == POS_CT_MID)
                begin
                    tag_hdr[15:8] = b;
                end
                else
                begin
                    // last composition time byte: pick the body layout
                    tag_hdr[7:0] = b;
                    len_acc      = '0;
                    len_seen     = '0;
                    if (tag_hdr[31:24] == PKT_SEQ_HDR)
                        cur_phase = P_CFG;
                    else if (tag_hdr[31:24] == PKT_NALU)
                        cur_phase = P_NAL_LEN;
                    else
                        cur_phase = P_SKIP;
                end
            end
            P_CFG:
            begin
                if (cur_pos == POS_NLS)
                    cur_nls = {1'b0, b[1:0]} + 3'd1;
                if (cur_pos >= POS_CFG_END)
                begin
                    cur_phase = P_SPS_LEN;
                    len_acc   = '0;
                    len_seen  = '0;
                end
            end
            P_SPS_LEN, P_PPS_LEN:
            begin
                len_acc  = {len_acc[23:0], b};
                len_seen = len_seen + 3'd1;
                if (len_seen >= PS_LEN_SIZE)
                begin
                    emit_start_code();
                    payload_left = {16'h0, len_acc[15:0]};
                    len_acc      = '0;
                    len_seen     = '0;
                    if (cur_phase == P_SPS_LEN)
                        cur_phase = (payload_left != 0) ? P_SPS_BODY : P_PPS_CNT;
                    else
                        cur_phase = (payload_left != 0) ? P_PPS_BODY : P_SKIP;
                end
            end
            P_SPS_BODY, P_PPS_BODY:
            begin
                emit(b, 1'b1);
                payload_left = payload_left - 1;
                if (payload_left == 0)
                    cur_phase = (cur_phase == P_SPS_BODY) ? P_PPS_CNT : P_SKIP;
            end
            P_PPS_CNT:
            begin
                cur_phase = P_PPS_LEN;
                len_acc   = '0;
                len_seen  = '0;
            end
            P_NAL_LEN:
            begin
                len_acc  = {len_acc[23:0], b};
                len_seen = len_seen + 3'd1;
                if (len_seen >= cur_nls)
                begin
                    emit_start_code();
                    payload_left = len_acc;
                    len_acc      = '0;
                    len_seen     = '0;
                    if (payload_left != 0)
                        cur_phase = P_NAL_BODY;
                end
            end
            P_NAL_BODY:
            begin
                emit(b, 1'b1);
                payload_left = payload_left - 1;
                if (payload_left == 0)
                    cur_phase = P_NAL_LEN;
            end
            default:
            begin
            end
        endcase

        if (cur_pos != '1)
            cur_pos = cur_pos + 1;

        if (last)
        begin
            // clean only when skipping or sitting exactly on a unit boundary
            trunc = !(cur_phase == P_SKIP || (cur_phase == P_NAL_LEN && len_seen == 0));
            if (burst.size() == 0)
                emit(8'h00, 1'b0);
            burst[$].end_of_tag = 1'b1;
            burst[$].truncated  = trunc;
            clear_tag_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer one tag byte, hold it until taken, then book the words
    // it owes. Typed rows book their own word instead of the model's.
    // ------------------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input logic video, input logic last,
                             input logic typed, input annexb_word_t gold);
        int gap;
        gap = (src_burst || sink_holding) ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            tag_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tag_if.valid        <= 1'b1;
        tag_if.tag_byte     <= b;
        tag_if.tag_is_video <= video;
        tag_if.last_byte    <= last;
        do
            @(posedge clk);
        while (!tag_if.ready);
        convert_byte(b, video, last);
        if (typed)
            expected_words.push_back(gold);
        else
            foreach (burst[i])
                expected_words.push_back(burst[i]);
    endtask

    // Directed tags: three one-byte tags (foreign codec, AVC cut inside its
    // header, AVC with a non-video tag type), a sequence header at the maximum
    // composition time with zero-length SPS and PPS and a one-byte NAL length
    // size, then a NALU tag at composition time zero with payload extremes.
    stim_row_t directed_rows [27] = '{
        '{8'hFF, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 4'hF, 4'hF, 8'h00, 24'h0, 1'b0}},
        '{8'h17, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 4'h1, 4'h7, 8'h00, 24'h0, 1'b1}},
        '{8'h07, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 4'h0, 4'h7, 8'h00, 24'h0, 1'b0}},
        '{8'h17, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{8'hFF, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{8'hFF, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{8'h01, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{8'h64, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{8'h1F, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{8'hFC, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{8'hE1, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{8'h01, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_WORD},
        '{8'h27, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{8'h01, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{8'h02, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, 1'b1, 1'b0, NO_WORD}
    };

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, then random tags until enough AVC
    // bytes went through. Most random tags are well formed with random
    // content; some are cut short, some carry huge lengths, some are noise.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [7:0]  tag_body[$];
        logic [7:0]  hdr_byte;
        logic [31:0] nal_len;
        logic        is_video;
        logic        is_avc;
        int          shape;
        int          units;
        int          cut;
        int          avc_bytes;

        rst_n                <= 1'b0;
        tag_if.valid         <= 1'b0;
        tag_if.tag_byte      <= 8'h00;
        tag_if.tag_is_video  <= 1'b0;
        tag_if.last_byte     <= 1'b0;
        cur_nls = NLS_RESET;
        clear_tag_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_word(directed_rows[r].tag_byte, directed_rows[r].video,
                      directed_rows[r].last, directed_rows[r].typed, directed_rows[r].gold);

        avc_bytes = 0;
        while (avc_bytes < RANDOM_BYTES)
        begin
            tag_body.delete();
            is_video = 1'b1;
            is_avc   = 1'b1;
            shape    = $urandom_range(0, 9);
            hdr_byte = {4'($urandom_range(0, 15)), CODEC_AVC};
            tag_body.push_back(hdr_byte);
            if (shape < 3)
            begin
                // sequence header: config record prefix, one SPS, one PPS
                tag_body.push_back(PKT_SEQ_HDR);
                repeat (9) tag_body.push_back(8'($urandom()));  // ct, prefix, NLS, count
                if ($urandom_range(0, 11) == 0)
                begin
                    // oversized SPS length: tag ends inside it
                    tag_body.push_back(8'($urandom()));
                    tag_body.push_back(8'($urandom()));
                    repeat ($urandom_range(1, 3)) tag_body.push_back(8'($urandom()));
                end
                else
                begin
                    units = $urandom_range(0, 4);
                    tag_body.push_back(8'h00);
                    tag_body.push_back(8'(units));
                    repeat (units) tag_body.push_back(8'($urandom()));
                    tag_body.push_back(8'($urandom()));
                    units = $urandom_range(0, 3);
                    tag_body.push_back(8'h00);
                    tag_body.push_back(8'(units));
                    repeat (units) tag_body.push_back(8'($urandom()));
                    repeat ($urandom_range(0, 2)) tag_body.push_back(8'($urandom()));
                end
            end
            else if (shape < 8)
            begin
                // NALU packet: a few length-prefixed units at the current size
                tag_body.push_back(PKT_NALU);
                repeat (3) tag_body.push_back(8'($urandom()));
                units = $urandom_range(0, 3);
                for (int u = 0; u < units; u++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        nal_len = $urandom();
                        for (int k = int'(cur_nls) - 1; k >= 0; k--)
                            tag_body.push_back(nal_len[8*k +: 8]);
                        repeat ($urandom_range(1, 3)) tag_body.push_back(8'($urandom()));
                        break;
                    end
                    nal_len = $urandom_range(0, 6);
                    for (int k = int'(cur_nls) - 1; k >= 0; k--)
                        tag_body.push_back(nal_len[8*k +: 8]);
                    repeat (nal_len) tag_body.push_back(8'($urandom()));
                end
            end
            else if (shape == 8)
            begin
                // AVC with end-of-sequence or an unknown packet type
                is_avc = 1'b0;
                tag_body.push_back(($urandom_range(0, 1) == 0) ? 8'd2
                                                               : 8'($urandom_range(2, 255)));
                repeat (3 + $urandom_range(0, 3)) tag_body.push_back(8'($urandom()));
            end
            else
            begin
                // foreign codec or non-video tag type
                is_avc      = 1'b0;
                tag_body[0] = 8'($urandom());
                is_video    = 1'($urandom_range(0, 1));
                if (is_video && tag_body[0][3:0] == CODEC_AVC)
                    is_video = 1'b0;
                repeat ($urandom_range(0, 4)) tag_body.push_back(8'($urandom()));
            end

            // cut some AVC tags short anywhere, header included
            if (is_avc && tag_body.size() > 1 && $urandom_range(0, 4) == 0)
            begin
                cut = $urandom_range(1, tag_body.size() - 1);
                while (tag_body.size() > cut)
                    void'(tag_body.pop_back());
            end

            src_burst = ($urandom_range(0, 3) == 0);
            foreach (tag_body[i])
                send_word(tag_body[i], (i == 0) ? is_video : 1'($urandom_range(0, 1)),
                          i == tag_body.size() - 1, 1'b0, NO_WORD);
            if (is_avc)
                avc_bytes += tag_body.size();
        end
        src_burst = 1'b0;
        tag_if.valid <= 1'b0;

        // drain, then give stray words a chance to show up
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sink: random gaps per word, runs without gaps, and recurring long hold-offs
    // that fill the block's queue and stall its input. Each taken word is
    // checked against the oldest expected word.
    // ------------------------------------------------------------------
    initial
    begin : sink_side
        annexb_word_t got;
        annexb_word_t want;
        int           gap;
        int           words_taken;
        int           next_hold;
        int           run_left;
        logic         run_fast;

        annexb_if.ready <= 1'b0;
        words_taken = 0;
        next_hold   = 60;
        run_left    = 0;
        run_fast    = 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (words_taken == next_hold)
            begin
                // hold off long enough for the input side to back up
                sink_holding = 1'b1;
                annexb_if.ready <= 1'b0;
                repeat (SINK_HOLD) @(posedge clk);
                sink_holding = 1'b0;
                next_hold += 260;
            end
            if (run_left == 0)
            begin
                run_left = $urandom_range(1, 40);
                run_fast = ($urandom_range(0, 2) == 0);
            end
            run_left--;
            gap = run_fast ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                annexb_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            annexb_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!annexb_if.valid);

            got.out_byte         = annexb_if.out_byte;
            got.byte_valid       = annexb_if.byte_valid;
            got.end_of_tag       = annexb_if.end_of_tag;
            got.frame_type       = annexb_if.frame_type;
            got.codec_id         = annexb_if.codec_id;
            got.packet_kind      = annexb_if.packet_kind;
            got.composition_time = annexb_if.composition_time;
            got.truncated        = annexb_if.truncated;

            if (expected_words.size() == 0)
            begin
                if (mismatches < 10)
                    $display("word %0d: nothing expected, got byte %h bv %b eot %b tr %b",
                             words_taken, got.out_byte, got.byte_valid, got.end_of_tag,
                             got.truncated);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (got !== want)
                begin
                    if (mismatches < 10)
                    begin
                        $display("word %0d exp: byte %h bv %b eot %b ft %h cid %h pk %h ct %h tr %b",
                                 words_taken, want.out_byte, want.byte_valid,
                                 want.end_of_tag, want.frame_type, want.codec_id,
                                 want.packet_kind, want.composition_time, want.truncated);
                        $display("word %0d got: byte %h bv %b eot %b ft %h cid %h pk %h ct %h tr %b",
                                 words_taken, got.out_byte, got.byte_valid,
                                 got.end_of_tag, got.frame_type, got.codec_id,
                                 got.packet_kind, got.composition_time, got.truncated);
                    end
                    mismatches++;
                end
            end
            words_taken++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles in which neither side moves a word.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((tag_if.valid && tag_if.ready) || (annexb_if.valid && annexb_if.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule
